>>> sv/urf_pkg.sv
// ----------------------------------------------------------------------------
// urf_pkg: shared types and constants of the UTF-8 rune range filter
// Holds the channel payload types and the register codes. It also holds the
// group type that the front hands to the back and the UTF-8 lead byte helpers.
// ----------------------------------------------------------------------------
package urf_pkg;

  // Most bytes that one input item can release.
  localparam int SLOTS = 4;

  // Groups buffered between front and back (a power of two).
  localparam int QUEUE_DEPTH = 4;

  // Configuration port widths.
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_START  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEEP_MODE    = 2'd2;

  // One input item.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
    logic       no_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } result_t;

  // Bytes released by one item, with a pass mask per slot and the end flag.
  typedef struct packed {
    logic [SLOTS-1:0][7:0] bytes;
    logic [SLOTS-1:0]      mask;
    logic                  last;
  } group_t;

  // Decoded range: runes with lo <= index < hi are inside when active is set.
  typedef struct packed {
    logic        active;
    logic        keep_mode;
    logic [30:0] lo;
    logic [31:0] hi;
  } range_t;

  // Continuation bytes that a lead byte expects; zero for a one-byte rune.
  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if ((b & 8'hE0) == 8'hC0) begin
      n = 2'd1;
    end else if ((b & 8'hF0) == 8'hE0) begin
      n = 2'd2;
    end else if ((b & 8'hF8) == 8'hF0) begin
      n = 2'd3;
    end
    return n;
  endfunction

  // True for a continuation byte (10xxxxxx).
  function automatic logic is_cont(input logic [7:0] b);
    return (b & 8'hC0) == 8'h80;
  endfunction

endpackage

>>> sv/urf_config.sv
// ----------------------------------------------------------------------------
// urf_config: configuration registers of the rune range filter
// Stores the range start, range length and mode. It decodes them at write
// time into the bounds that the front compares rune indexes against.
// ----------------------------------------------------------------------------
module urf_config
  import urf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      write_en,
  input  logic [CFG_INDEX_BITS-1:0] write_index,
  input  logic [CFG_DATA_BITS-1:0]  write_data,
  output range_t                    rng
);

  logic [31:0] range_start;
  logic [31:0] range_start_next;
  logic [31:0] range_length;
  logic [31:0] range_length_next;
  logic        keep_mode;
  logic        keep_mode_next;
  logic [32:0] hi_sum;
  range_t      rng_next;

  // Select the written register; an index beyond the list changes nothing.
  always_comb begin
    range_start_next  = range_start;
    range_length_next = range_length;
    keep_mode_next    = keep_mode;
    if (write_en) begin
      case (write_index)
        REG_RANGE_START:  range_start_next  = write_data;
        REG_RANGE_LENGTH: range_length_next = write_data;
        REG_KEEP_MODE:    keep_mode_next    = write_data[0];
        default: ;
      endcase
    end
  end

  // Decode the bounds from the new values. The range is live only when the
  // length and the end are both positive; the end then fits in 32 bits.
  always_comb begin
    hi_sum = {range_start_next[31], range_start_next}
           + {range_length_next[31], range_length_next};
    rng_next.active    = !range_length_next[31] && (|range_length_next)
                       && !hi_sum[32] && (|hi_sum);
    rng_next.keep_mode = keep_mode_next;
    rng_next.lo        = range_start_next[31] ? 31'd0 : range_start_next[30:0];
    rng_next.hi        = hi_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start  <= '0;
      range_length <= '0;
      keep_mode    <= 1'b0;
      rng          <= '0;
    end else begin
      range_start  <= range_start_next;
      range_length <= range_length_next;
      keep_mode    <= keep_mode_next;
      rng          <= rng_next;
    end
  end

endmodule

>>> sv/urf_front.sv
// ----------------------------------------------------------------------------
// urf_front: byte parser and rune classifier
// Accepts one byte per cycle while accept is high, splits the stream into
// UTF-8 runes and numbers them. It marks each released byte as passed or
// dropped and pushes the bytes of one item to the queue as a group.
// ----------------------------------------------------------------------------
module urf_front
  import urf_pkg::*;
#(
  parameter int INDEX_BITS = 32
) (
  input  logic   clk,
  input  logic   rst,
  input  item_t  item,
  input  logic   accept,
  input  range_t rng,
  output group_t group,
  output logic   group_push
);

  localparam int CW = (INDEX_BITS > 32) ? INDEX_BITS : 32;
  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

  logic [2:0][7:0]        held_bytes;
  logic [1:0]             held_count;
  logic [1:0]             rune_needed;
  logic [INDEX_BITS-1:0]  rune_count;

  logic [2:0][7:0]        hb;
  logic [1:0]             hc;
  logic [1:0]             nd;
  logic [2:0]             nr;
  logic [SLOTS-1:0][7:0]  sb;
  logic [SLOTS-1:0][1:0]  sr;
  logic [SLOTS-1:0]       sv;
  logic [SLOTS-1:0]       pass;
  logic [SLOTS-1:0]       mask;
  logic [INDEX_BITS:0]    next_sum;
  logic [INDEX_BITS-1:0]  rune_count_next;

  // Pass decision for the first few runes that this item can close.
  always_comb begin
    logic [INDEX_BITS:0]   sum;
    logic [INDEX_BITS-1:0] idx;
    logic                  in_rng;
    for (int k = 0; k < SLOTS; k++) begin
      sum    = {1'b0, rune_count} + (INDEX_BITS+1)'(k);
      idx    = sum[INDEX_BITS] ? IDX_MAX : sum[INDEX_BITS-1:0];
      in_rng = rng.active && (CW'(idx) >= CW'(rng.lo)) && (CW'(idx) < CW'(rng.hi));
      pass[k] = rng.keep_mode ? !in_rng : in_rng;
    end
  end

  // Parse the byte, then handle the end of the string. Released bytes fill
  // the slots in order, each tagged with the number of its rune.
  always_comb begin
    logic [2:0] nb;
    logic [7:0] b;
    hb = held_bytes;
    hc = held_count;
    nd = rune_needed;
    nr = 3'd0;
    nb = 3'd0;
    sb = '0;
    sr = '0;
    sv = '0;
    b  = item.text_byte;
    if (!item.no_byte) begin
      if (hc == 2'd0) begin
        // A fresh byte: either a one-byte rune or a new lead.
        if (lead_need(b) == 2'd0) begin
          sb[nb[1:0]] = b;
          sr[nb[1:0]] = nr[1:0];
          sv[nb[1:0]] = 1'b1;
          nb = nb + 3'd1;
          nr = nr + 3'd1;
        end else begin
          hb[0] = b;
          hc    = 2'd1;
          nd    = lead_need(b);
        end
      end else if (is_cont(b)) begin
        if (hc >= nd) begin
          // The last continuation byte completes the held rune.
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < hc) begin
              sb[nb[1:0]] = hb[i];
              sr[nb[1:0]] = nr[1:0];
              sv[nb[1:0]] = 1'b1;
              nb = nb + 3'd1;
            end
          end
          sb[nb[1:0]] = b;
          sr[nb[1:0]] = nr[1:0];
          sv[nb[1:0]] = 1'b1;
          nb = nb + 3'd1;
          nr = nr + 3'd1;
          hc = 2'd0;
          nd = 2'd0;
        end else begin
          hb[hc] = b;
          hc     = hc + 2'd1;
        end
      end else begin
        // The held lead fails: each held byte becomes a rune of its own.
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < hc) begin
            sb[nb[1:0]] = hb[i];
            sr[nb[1:0]] = nr[1:0];
            sv[nb[1:0]] = 1'b1;
            nb = nb + 3'd1;
            nr = nr + 3'd1;
          end
        end
        hc = 2'd0;
        nd = 2'd0;
        if (lead_need(b) == 2'd0) begin
          sb[nb[1:0]] = b;
          sr[nb[1:0]] = nr[1:0];
          sv[nb[1:0]] = 1'b1;
          nb = nb + 3'd1;
          nr = nr + 3'd1;
        end else begin
          hb[0] = b;
          hc    = 2'd1;
          nd    = lead_need(b);
        end
      end
    end
    if (item.end_of_text) begin
      // At the end a still open rune fails the same way.
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < hc) begin
          sb[nb[1:0]] = hb[i];
          sr[nb[1:0]] = nr[1:0];
          sv[nb[1:0]] = 1'b1;
          nb = nb + 3'd1;
          nr = nr + 3'd1;
        end
      end
      hc = 2'd0;
      nd = 2'd0;
    end
  end

  // Mask each slot with the decision for its rune.
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      mask[j] = sv[j] && pass[sr[j]];
    end
  end

  // Saturating rune counter, back to zero after each end.
  always_comb begin
    next_sum = {1'b0, rune_count} + (INDEX_BITS+1)'(nr);
    if (item.end_of_text) begin
      rune_count_next = '0;
    end else if (next_sum[INDEX_BITS]) begin
      rune_count_next = IDX_MAX;
    end else begin
      rune_count_next = next_sum[INDEX_BITS-1:0];
    end
  end

  // A group goes out when it carries a passed byte or closes the string.
  assign group.bytes = sb;
  assign group.mask  = mask;
  assign group.last  = item.end_of_text;
  assign group_push  = accept && ((|mask) || item.end_of_text);

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count  <= 2'd0;
      rune_needed <= 2'd0;
      rune_count  <= '0;
    end else if (accept) begin
      held_count  <= hc;
      rune_needed <= nd;
      rune_count  <= rune_count_next;
    end
  end

  // Held bytes carry data only and need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes <= hb;
    end
  end

endmodule

>>> sv/urf_queue.sv
// ----------------------------------------------------------------------------
// urf_queue: group queue between front and back
// A small first-in first-out buffer of byte groups. The head entry is shown
// directly so that the back can serialize it.
// ----------------------------------------------------------------------------
module urf_queue
  import urf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  group_t wr_group,
  input  logic   wr_en,
  input  logic   rd_en,
  output group_t head,
  output logic   head_valid,
  output logic   q_full
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  group_t              entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign q_full     = (count == (PTR_BITS+1)'(QUEUE_DEPTH));

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (PTR_BITS+1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (PTR_BITS+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_group;
    end
  end

endmodule

>>> sv/urf_back.sv
// ----------------------------------------------------------------------------
// urf_back: result serializer
// Walks the passed bytes of the head group one per transaction. It marks the
// last byte of a string and stands in an empty closing result when an end
// group passed nothing.
// ----------------------------------------------------------------------------
module urf_back
  import urf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  group_t  head,
  input  logic    head_valid,
  output logic    head_pop,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  logic [SLOTS-1:0] taken;
  logic [SLOTS-1:0] rem;
  logic [SLOTS-1:0] pick;
  logic [SLOTS-1:0] rest;
  logic [7:0]       sel_byte;
  logic             xfer;

  // Lowest passed byte not yet delivered.
  always_comb begin
    rem      = head.mask & ~taken;
    pick     = rem & (~rem + SLOTS'(1));
    rest     = rem & ~pick;
    sel_byte = 8'd0;
    for (int j = 0; j < SLOTS; j++) begin
      if (pick[j]) begin
        sel_byte = head.bytes[j];
      end
    end
  end

  assign empty            = !head_valid;
  assign result.out_byte  = sel_byte;
  assign result.out_valid = |rem;
  assign result.out_last  = head.last && (rest == '0);

  // The group leaves the queue with its final transaction.
  assign xfer     = pop && head_valid;
  assign head_pop = xfer && (rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else if (xfer) begin
      if (rest == '0) begin
        taken <= '0;
      end else begin
        taken <= taken | pick;
      end
    end
  end

endmodule

>>> sv/utf8_rune_range_filter.sv
// ----------------------------------------------------------------------------
// utf8_rune_range_filter: UTF-8 rune range filter, top level
// Splits a byte string into runes and passes the runes whose index lies in a
// configured range (substring) or outside it (remove).
//
//   channel   handshake        payload     moves
//   item      push / full      item_t      one string byte or an end marker
//   result    empty / pop      result_t    one output byte or empty close
//   config    write_en         index,data  one register write
//
// An item is accepted in every cycle in which the queue has room; the parse
// and the range compare of one byte are combinational in the front.
// Results leave at one per cycle while pop is high; an item that releases N
// bytes holds the back for N pops, so the sustained rate is one byte of
// output per cycle. An accepted item's results wait behind the groups
// ahead of it. A four-group queue lets the front run on while results stall.
// Synchronous reset clears all control state.
// ----------------------------------------------------------------------------
module utf8_rune_range_filter
  import urf_pkg::*;
#(
  parameter int INDEX_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  item_t                     item,
  output logic                      empty,
  input  logic                      pop,
  output result_t                   result,
  input  logic                      write_en,
  input  logic [CFG_INDEX_BITS-1:0] write_index,
  input  logic [CFG_DATA_BITS-1:0]  write_data
);

  range_t rng;
  group_t group;
  group_t head;
  logic   group_push;
  logic   head_valid;
  logic   head_pop;
  logic   accept;

  assign accept = push && !full;

  // Configuration registers and decoded range.
  urf_config u_config (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .rng         (rng)
  );

  // Parser and classifier.
  urf_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .accept     (accept),
    .rng        (rng),
    .group      (group),
    .group_push (group_push)
  );

  // Decoupling queue.
  urf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_group   (group),
    .wr_en      (group_push),
    .rd_en      (head_pop),
    .head       (head),
    .head_valid (head_valid),
    .q_full     (full)
  );

  // Result serializer.
  urf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

>>> sv/urf_checker.sv
// ----------------------------------------------------------------------------
// urf_checker: port-level checks of the rune range filter
// Watches the top-level ports over time and reports violations.
// ----------------------------------------------------------------------------
module urf_checker
  import urf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      full,
  input  item_t                     item,
  input  logic                      empty,
  input  logic                      pop,
  input  result_t                   result
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results pending after reset");

  // A waiting result that is not taken stays on the ports.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before it was taken");

  // An empty closing result carries a zero byte and closes the string.
  a_close_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.out_valid) |-> (result.out_last && result.out_byte == 8'd0))
    else $error("malformed empty closing result");

  // An accepted end of string always yields a result.
  a_end_yields: assert property (@(posedge clk) disable iff (rst)
    (push && !full && item.end_of_text && empty) |=> !empty)
    else $error("end of string produced no result");

endmodule

bind utf8_rune_range_filter urf_checker u_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the UTF-8 rune range filter
// A short table of hand-picked strings comes first, most with the obvious results
// typed in, followed by random strings that are mostly well-formed UTF-8 with
// some noise and broken leads mixed in. A local rune splitter and range filter
// predicts every output transaction, and each one is compared field by field.
// Sender gaps, receiver stalls and one long receiver hold-off vary the timing.
// ----------------------------------------------------------------------------
module testbench;
  import urf_pkg::*;

  localparam int INDEX_BITS    = 32;
  localparam int MAX_OUT       = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_CYCLES   = 60;
  localparam int LIMIT_CYCLES  = 300000;
  localparam int PHASE_ITEMS   = 100;
  localparam int NUM_PHASES    = 4;

  // Spare register index; writes to it must be ignored.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  // Empty closing result of a string with nothing passed.
  localparam result_t CLOSE = '{8'h00, 1'b0, 1'b1};

  // Per-phase percentages of sender gaps and receiver stalls.
  localparam int SEND_IDLE [NUM_PHASES] = '{0, 61, 0, 26};
  localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 61, 26};

  // One row of the directed table: a register write or one input item.
  typedef struct packed {
    logic                      is_write;
    logic [CFG_INDEX_BITS-1:0] reg_idx;
    logic [CFG_DATA_BITS-1:0]  reg_val;
    item_t                     it;
    logic                      typed;
    logic [2:0]                n_typed;
    result_t [3:0]             want;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      push;
  logic                      full;
  item_t                     item;
  logic                      empty;
  logic                      pop;
  result_t                   result;
  logic                      write_en;
  logic [CFG_INDEX_BITS-1:0] write_index;
  logic [CFG_DATA_BITS-1:0]  write_data;

  // Shadow of the parser state and the range registers.
  logic [7:0]            held_q [3];
  int unsigned           held_n;
  int unsigned           need_n;
  logic [INDEX_BITS-1:0] rune_idx;
  logic signed [31:0]    cfg_start;
  logic signed [31:0]    cfg_length;
  logic                  cfg_remove;

  // Bytes passed by the current item, its results, and results still awaited.
  logic [7:0] passed_bytes[$];
  result_t    step_out[$];
  result_t    awaited_out[$];
  result_t    head;

  int  idle_pct;
  int  stall_pct;
  bit  hold_start;
  int  hold_left;
  int  cycle_count;
  int  mismatch_count;
  int  items_sent;
  int  results_checked;
  int  strings_sent;
  int  writes_done;

  dir_row_t plan[$];

  utf8_rune_range_filter #(
    .INDEX_BITS(INDEX_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .write_en(write_en),
    .write_index(write_index),
    .write_data(write_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench: timeout after %0d cycles", cycle_count);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A rune passes when its index is inside the range in substring mode, or
  // outside it in remove mode.
  function automatic bit rune_selected(input logic [INDEX_BITS-1:0] idx);
    longint lo;
    longint hi;
    bit     in_range;
    in_range = 1'b0;
    if (cfg_length > 0) begin
      lo = (cfg_start < 0) ? 64'sd0 : longint'(cfg_start);
      hi = longint'(cfg_start) + longint'(cfg_length);
      in_range = (longint'(idx) >= lo) && (longint'(idx) < hi);
    end
    return cfg_remove ? !in_range : in_range;
  endfunction

  // Decide one rune of n bytes; the index saturates at its top value.
  function automatic void release_rune(input logic [3:0][7:0] rb, input int n);
    if (rune_selected(rune_idx)) begin
      for (int k = 0; k < n; k++) begin
        if (passed_bytes.size() < MAX_OUT) begin
          passed_bytes.push_back(rb[k]);
        end
      end
    end
    if (rune_idx != '1) begin
      rune_idx++;
    end
  endfunction

  // Every held byte becomes a rune of its own.
  function automatic void flush_held();
    for (int k = 0; k < held_n; k++) begin
      release_rune({24'h0, held_q[k]}, 1);
    end
    held_n = 0;
    need_n = 0;
  endfunction

  // A byte with nothing held: either a lead to hold or a one-byte rune.
  function automatic void open_rune(input logic [7:0] b);
    int unsigned extra;
    casez (b)
      8'b110?????: extra = 1;
      8'b1110????: extra = 2;
      8'b11110???: extra = 3;
      default:     extra = 0;
    endcase
    if (extra == 0) begin
      release_rune({24'h0, b}, 1);
    end else begin
      held_q[0] = b;
      held_n    = 1;
      need_n    = extra;
    end
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    logic [3:0][7:0] rb;
    if (held_n == 0) begin
      open_rune(b);
    end else if (b[7:6] == 2'b10) begin
      if (held_n >= need_n) begin
        rb = '0;
        for (int k = 0; k < held_n; k++) begin
          rb[k] = held_q[k];
        end
        rb[held_n] = b;
        release_rune(rb, held_n + 1);
        held_n = 0;
        need_n = 0;
      end else begin
        held_q[held_n] = b;
        held_n++;
      end
    end else begin
      flush_held();
      open_rune(b);
    end
  endfunction

  // Results that one accepted item releases, left in step_out.
  function automatic void split_and_filter(input item_t it);
    passed_bytes.delete();
    step_out.delete();
    if (!it.no_byte) begin
      absorb_byte(it.text_byte);
    end
    if (it.end_of_text) begin
      flush_held();
      rune_idx = '0;
    end
    foreach (passed_bytes[k]) begin
      step_out.push_back('{passed_bytes[k], 1'b1,
                           it.end_of_text && (k == passed_bytes.size() - 1)});
    end
    if (it.end_of_text && passed_bytes.size() == 0) begin
      step_out.push_back(CLOSE);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Pop decision per cycle; a requested hold-off keeps pop low for a while.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Each popped transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (awaited_out.size() == 0) begin
        $error("unexpected result: byte %h valid %b last %b",
               result.out_byte, result.out_valid, result.out_last);
        mismatch_count++;
      end else begin
        head = awaited_out.pop_front();
        results_checked++;
        if (result.out_byte !== head.out_byte) begin
          $error("out_byte: expected %h, got %h", head.out_byte, result.out_byte);
          mismatch_count++;
        end
        if (result.out_valid !== head.out_valid) begin
          $error("out_valid: expected %b, got %b", head.out_valid, result.out_valid);
          mismatch_count++;
        end
        if (result.out_last !== head.out_last) begin
          $error("out_last: expected %b, got %b", head.out_last, result.out_last);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap; predict at the accepting edge.
  // Entered and left at a falling edge, with push still high.
  task automatic send_item(input item_t it, input bit use_typed, input int n_typed,
                           input result_t [3:0] typed);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    split_and_filter(it);
    if (use_typed) begin
      for (int k = 0; k < n_typed; k++) begin
        awaited_out.push_back(typed[k]);
      end
    end else begin
      foreach (step_out[k]) begin
        awaited_out.push_back(step_out[k]);
      end
    end
    if (!it.no_byte || it.end_of_text) begin
      items_sent++;
    end
    @(negedge clk);
  endtask

  // Let the block run dry before a register write.
  task automatic settle();
    push <= 1'b0;
    while (awaited_out.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    write_en    <= 1'b1;
    write_index <= idx;
    write_data  <= val;
    @(negedge clk);
    write_en <= 1'b0;
    case (idx)
      REG_RANGE_START:  cfg_start  = val;
      REG_RANGE_LENGTH: cfg_length = val;
      REG_KEEP_MODE:    cfg_remove = val[0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic dir_row_t row_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                         input logic [CFG_DATA_BITS-1:0] val);
    dir_row_t r;
    r          = '0;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_val  = val;
    return r;
  endfunction

  // Item row; with typed set, the listed results replace the prediction.
  function automatic dir_row_t row_item(input logic [7:0] b, input logic eot,
                                        input logic nob, input bit typed = 1'b0,
                                        input int n = 0,
                                        input result_t r0 = '0, input result_t r1 = '0,
                                        input result_t r2 = '0, input result_t r3 = '0);
    dir_row_t r;
    r         = '0;
    r.it      = '{b, eot, nob};
    r.typed   = typed;
    r.n_typed = 3'(n);
    r.want    = {r3, r2, r1, r0};
    return r;
  endfunction

  function automatic result_t byte_out(input logic [7:0] b, input logic last);
    return '{b, 1'b1, last};
  endfunction

  // Lead byte of a rune with the given number of continuation bytes.
  function automatic logic [7:0] lead_byte(input int extra);
    logic [7:0] r;
    r = 8'($urandom());
    case (extra)
      1:       return {3'b110, r[4:0]};
      2:       return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic logic [7:0] tail_byte();
    logic [7:0] r;
    r = 8'($urandom());
    return {2'b10, r[5:0]};
  endfunction

  // Mostly small values so ranges cut into strings, plus the extremes.
  function automatic logic [CFG_DATA_BITS-1:0] pick_cfg_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($urandom());
      default: return 32'($urandom_range(16)) - 32'd4;
    endcase
  endfunction

  task automatic shuffle_range();
    settle();
    if ($urandom_range(1) == 1) begin
      write_reg(REG_RANGE_START, pick_cfg_value());
    end
    if ($urandom_range(1) == 1) begin
      write_reg(REG_RANGE_LENGTH, pick_cfg_value());
    end
    if ($urandom_range(2) == 0) begin
      write_reg(REG_KEEP_MODE, 32'($urandom()));
    end
    if ($urandom_range(9) == 0) begin
      write_reg(REG_SPARE, 32'($urandom()));
    end
  endtask

  // One random string: mostly well-formed runes, some noise and cut leads.
  task automatic send_string();
    logic [7:0] text[$];
    int         runes;
    int         extra;
    int         tails;
    bit         sep_end;
    item_t      it;
    runes = $urandom_range(10);
    for (int r = 0; r < runes; r++) begin
      case ($urandom_range(9))
        0, 1, 2: text.push_back({1'b0, 7'($urandom())});
        3, 4, 5, 6, 7: begin
          extra = ($urandom_range(3) == 0) ? 3 : $urandom_range(1, 2);
          text.push_back(lead_byte(extra));
          repeat (extra) text.push_back(tail_byte());
        end
        8: text.push_back(8'($urandom()));
        default: begin
          // Lead cut short, or a stray continuation byte.
          extra = $urandom_range(1, 3);
          tails = $urandom_range(extra - 1);
          if ($urandom_range(3) != 0) begin
            text.push_back(lead_byte(extra));
          end
          repeat (tails) text.push_back(tail_byte());
        end
      endcase
    end
    sep_end = (text.size() == 0) || ($urandom_range(4) == 0);
    foreach (text[k]) begin
      // An empty item in mid-string must do nothing.
      if ($urandom_range(19) == 0) begin
        it = '{8'($urandom()), 1'b0, 1'b1};
        send_item(it, 1'b0, 0, '0);
      end
      it = '{text[k], !sep_end && (k == text.size() - 1), 1'b0};
      send_item(it, 1'b0, 0, '0);
    end
    if (sep_end) begin
      it = '{8'($urandom()), 1'b1, 1'b1};
      send_item(it, 1'b0, 0, '0);
    end
    strings_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int target;
    rst         = 1'b1;
    push        = 1'b0;
    item        = '0;
    write_en    = 1'b0;
    write_index = '0;
    write_data  = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_start  = 1'b0;
    hold_left   = 0;
    held_n      = 0;
    need_n      = 0;
    rune_idx    = '0;
    cfg_start   = '0;
    cfg_length  = '0;
    cfg_remove  = 1'b0;

    // Directed strings. After reset the range is empty in substring mode, so
    // nothing passes; in remove mode with an empty range every rune passes.
    plan.push_back(row_item(8'h41, 1'b0, 1'b0, 1'b1, 0));
    plan.push_back(row_item(8'hFF, 1'b1, 1'b0, 1'b1, 1, CLOSE));
    plan.push_back(row_item(8'h00, 1'b1, 1'b1, 1'b1, 1, CLOSE));
    plan.push_back(row_write(REG_KEEP_MODE, 32'h0000_0001));
    // Zero byte as an ordinary rune.
    plan.push_back(row_item(8'h00, 1'b1, 1'b0, 1'b1, 1, byte_out(8'h00, 1'b1)));
    plan.push_back(row_item(8'h7F, 1'b0, 1'b0, 1'b1, 1, byte_out(8'h7F, 1'b0)));
    plan.push_back(row_item(8'hFF, 1'b1, 1'b0, 1'b1, 1, byte_out(8'hFF, 1'b1)));
    // An empty item without an end does nothing.
    plan.push_back(row_item(8'hA5, 1'b0, 1'b1, 1'b1, 0));
    plan.push_back(row_item(8'hC3, 1'b0, 1'b0, 1'b1, 0));
    plan.push_back(row_item(8'hA9, 1'b1, 1'b0, 1'b1, 2,
                            byte_out(8'hC3, 1'b0), byte_out(8'hA9, 1'b1)));
    plan.push_back(row_item(8'hF0, 1'b0, 1'b0, 1'b1, 0));
    plan.push_back(row_item(8'h9F, 1'b0, 1'b0, 1'b1, 0));
    plan.push_back(row_item(8'h98, 1'b0, 1'b0, 1'b1, 0));
    plan.push_back(row_item(8'h80, 1'b1, 1'b0, 1'b1, 4,
                            byte_out(8'hF0, 1'b0), byte_out(8'h9F, 1'b0),
                            byte_out(8'h98, 1'b0), byte_out(8'h80, 1'b1)));
    // Overlong two-byte lead still pairs with its continuation.
    plan.push_back(row_item(8'hC0, 1'b0, 1'b0, 1'b1, 0));
    plan.push_back(row_item(8'h80, 1'b1, 1'b0, 1'b1, 2,
                            byte_out(8'hC0, 1'b0), byte_out(8'h80, 1'b1)));
    // End arrives while a lead and a continuation are held.
    plan.push_back(row_item(8'hE2, 1'b0, 1'b0, 1'b1, 0));
    plan.push_back(row_item(8'h82, 1'b0, 1'b0, 1'b1, 0));
    plan.push_back(row_item(8'h5A, 1'b1, 1'b1, 1'b1, 2,
                            byte_out(8'hE2, 1'b0), byte_out(8'h82, 1'b1)));
    // A held lead fails on an ASCII byte.
    plan.push_back(row_item(8'hE2, 1'b0, 1'b0, 1'b1, 0));
    plan.push_back(row_item(8'h41, 1'b1, 1'b0, 1'b1, 2,
                            byte_out(8'hE2, 1'b0), byte_out(8'h41, 1'b1)));
    // Substring of runes 1 and 2.
    plan.push_back(row_write(REG_RANGE_START, 32'd1));
    plan.push_back(row_write(REG_RANGE_LENGTH, 32'd2));
    plan.push_back(row_write(REG_KEEP_MODE, 32'h0000_0000));
    plan.push_back(row_item(8'h61, 1'b0, 1'b0));
    plan.push_back(row_item(8'hC3, 1'b0, 1'b0));
    plan.push_back(row_item(8'hA9, 1'b0, 1'b0));
    plan.push_back(row_item(8'h62, 1'b0, 1'b0));
    plan.push_back(row_item(8'h63, 1'b1, 1'b0));
    // Extreme start and length; the spare index must leave keep_mode alone.
    plan.push_back(row_write(REG_RANGE_START, 32'h8000_0000));
    plan.push_back(row_write(REG_RANGE_LENGTH, 32'h7FFF_FFFF));
    plan.push_back(row_write(REG_SPARE, 32'hFFFF_FFFF));
    plan.push_back(row_item(8'h41, 1'b1, 1'b0));
    // Negative start counts as zero.
    plan.push_back(row_write(REG_RANGE_START, 32'hFFFF_FFFF));
    plan.push_back(row_write(REG_RANGE_LENGTH, 32'd3));
    plan.push_back(row_item(8'h31, 1'b0, 1'b0));
    plan.push_back(row_item(8'h32, 1'b0, 1'b0));
    plan.push_back(row_item(8'h33, 1'b1, 1'b0));

    // Synchronous reset, released at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[r]) begin
      if (plan[r].is_write) begin
        settle();
        write_reg(plan[r].reg_idx, plan[r].reg_val);
      end else begin
        send_item(plan[r].it, plan[r].typed, plan[r].n_typed, plan[r].want);
      end
    end

    // Random strings over the idle and stall mixes.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      idle_pct  = SEND_IDLE[phase];
      stall_pct = RECV_STALL[phase];
      if (phase == 0) begin
        // Receiver holds off while the sender keeps pushing.
        hold_start = 1'b1;
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        send_string();
        if ($urandom_range(2) == 0) begin
          shuffle_range();
        end
      end
    end

    // Drain everything that is still in flight.
    push <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (awaited_out.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("testbench: %0d items in %0d random strings plus a directed table, %0d results",
             items_sent, strings_sent, results_checked);
    $display("testbench: %0d register writes, gap/stall mixes and one long result hold-off",
             writes_done);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
